### rtl/dmc_pkg.sv
// shared types and constants of the delta-modulation sample channel
// used by every module in rtl/; depends on nothing
`timescale 1ns / 1ps

package dmc_pkg;

    localparam int OpWidth      = 3;
    localparam int ByteWidth    = 8;
    localparam int DacWidth     = 7;
    localparam int AddrWidth    = 15;
    localparam int LengthWidth  = 12;
    localparam int PeriodWidth  = 9;
    localparam int CfgIdxWidth  = 3;
    localparam int CfgDataWidth = 9;

    localparam logic [PeriodWidth-1:0] PeriodReset = 9'd428;

    typedef enum logic [OpWidth-1:0] {
        OP_TICK  = 3'd0,
        OP_START = 3'd1,
        OP_STOP  = 3'd2,
        OP_BYTE  = 3'd3,
        OP_ACK   = 3'd4
    } opcode_t;

    typedef enum logic [CfgIdxWidth-1:0] {
        REG_SAMPLE_ADDRESS = 3'd0,
        REG_SAMPLE_LENGTH  = 3'd1,
        REG_PERIOD_RELOAD  = 3'd2,
        REG_LOOP_ENABLE    = 3'd3,
        REG_IRQ_ENABLE     = 3'd4
    } cfg_index_t;

    typedef struct packed {
        logic [ByteWidth-1:0]   sample_address;
        logic [ByteWidth-1:0]   sample_length;
        logic [PeriodWidth-1:0] period_reload;
        logic                   loop_enable;
        logic                   irq_enable;
    } cfg_t;

    typedef struct packed {
        logic [DacWidth-1:0]  dac_out;
        logic                 dma_request;
        logic [AddrWidth-1:0] fetch_address;
        logic                 irq_flag;
        logic                 active;
    } result_t;

endpackage

### rtl/dmc_cfg.sv
// configuration registers of the sample channel, written through a plain write port
// depends on dmc_pkg
`timescale 1ns / 1ps

module dmc_cfg
    import dmc_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    cfg_wr_en,
    input  logic [CfgIdxWidth-1:0]  cfg_index,
    input  logic [CfgDataWidth-1:0] cfg_wdata,
    output cfg_t                    cfg
);

    cfg_t cfg_reg;
    cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_wr_en)
        begin
            case (cfg_index_t'(cfg_index))
                REG_SAMPLE_ADDRESS: cfg_next.sample_address = cfg_wdata[ByteWidth-1:0];
                REG_SAMPLE_LENGTH:  cfg_next.sample_length  = cfg_wdata[ByteWidth-1:0];
                REG_PERIOD_RELOAD:  cfg_next.period_reload  = cfg_wdata[PeriodWidth-1:0];
                REG_LOOP_ENABLE:    cfg_next.loop_enable    = cfg_wdata[0];
                REG_IRQ_ENABLE:     cfg_next.irq_enable     = cfg_wdata[0];
                default:            cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.sample_address <= '0;
            cfg_reg.sample_length  <= '0;
            cfg_reg.period_reload  <= PeriodReset;
            cfg_reg.loop_enable    <= 1'b0;
            cfg_reg.irq_enable     <= 1'b0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

### rtl/dmc_core.sv
// channel state and its registered update for one request
// depends on dmc_pkg
`timescale 1ns / 1ps

module dmc_core
    import dmc_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 step_en,
    input  logic [OpWidth-1:0]   op,
    input  logic [ByteWidth-1:0] data,
    input  cfg_t                 cfg,
    output result_t              res
);

    logic [LengthWidth-1:0] bytes_left_reg, bytes_left_next;
    logic [AddrWidth-1:0]   read_pointer_reg, read_pointer_next;
    logic [PeriodWidth-1:0] period_count_reg, period_count_next;
    logic [2:0]             bit_index_reg, bit_index_next;
    logic [ByteWidth-1:0]   shift_byte_reg, shift_byte_next;
    logic                   shift_valid_reg, shift_valid_next;
    logic [ByteWidth-1:0]   buffer_byte_reg, buffer_byte_next;
    logic                   buffer_full_reg, buffer_full_next;
    logic [DacWidth-1:0]    dac_level_reg, dac_level_next;
    logic                   irq_pending_reg, irq_pending_next;
    logic [1:0]             fetch_delay_reg, fetch_delay_next;

    logic [PeriodWidth-1:0] period_dec;
    logic [LengthWidth-1:0] bytes_dec;
    logic [2:0]             bit_index_inc;
    logic [1:0]             fetch_dec;
    logic [AddrWidth-1:0]   start_pointer;
    logic [LengthWidth-1:0] start_length;
    logic                   req;

    assign period_dec    = period_count_reg - 1'b1;
    assign bytes_dec     = bytes_left_reg - 1'b1;
    assign bit_index_inc = bit_index_reg + 1'b1;
    assign fetch_dec     = fetch_delay_reg - 1'b1;
    // 0x4000 + address * 64 never carries past bit 14
    assign start_pointer = {1'b1, cfg.sample_address, 6'd0};
    assign start_length  = {cfg.sample_length, 4'd1};

    always_comb
    begin
        bytes_left_next   = bytes_left_reg;
        read_pointer_next = read_pointer_reg;
        period_count_next = period_count_reg;
        bit_index_next    = bit_index_reg;
        shift_byte_next   = shift_byte_reg;
        shift_valid_next  = shift_valid_reg;
        buffer_byte_next  = buffer_byte_reg;
        buffer_full_next  = buffer_full_reg;
        dac_level_next    = dac_level_reg;
        irq_pending_next  = irq_pending_reg;
        fetch_delay_next  = fetch_delay_reg;
        req               = 1'b0;

        case (opcode_t'(op))
            OP_TICK:
            begin
                period_count_next = period_dec;
                if (period_dec == '0)
                begin
                    // one output bit, lsb first; a move out of range is dropped
                    if (shift_valid_reg)
                    begin
                        if (shift_byte_reg[bit_index_reg])
                        begin
                            if (dac_level_reg <= 7'd125)
                                dac_level_next = dac_level_reg + 7'd2;
                        end
                        else
                        begin
                            if (dac_level_reg >= 7'd2)
                                dac_level_next = dac_level_reg - 7'd2;
                        end
                    end
                    bit_index_next = bit_index_inc;
                    if (bit_index_inc == '0)
                    begin
                        if (buffer_full_reg)
                        begin
                            shift_valid_next = 1'b1;
                            shift_byte_next  = buffer_byte_reg;
                            buffer_full_next = 1'b0;
                            if (bytes_left_reg != '0)
                                req = 1'b1;
                        end
                        else
                        begin
                            shift_valid_next = 1'b0;
                        end
                    end
                    period_count_next = cfg.period_reload;
                end
                if (fetch_delay_reg != '0)
                begin
                    fetch_delay_next = fetch_dec;
                    if (fetch_dec == '0)
                        req = 1'b1;
                end
            end
            OP_START:
            begin
                if (bytes_left_reg == '0)
                begin
                    read_pointer_next = start_pointer;
                    bytes_left_next   = start_length;
                    if (!buffer_full_reg)
                        fetch_delay_next = period_count_reg[0] ? 2'd2 : 2'd3;
                end
            end
            OP_STOP:
            begin
                bytes_left_next = '0;
            end
            OP_BYTE:
            begin
                if (bytes_left_reg != '0)
                begin
                    buffer_byte_next  = data;
                    buffer_full_next  = 1'b1;
                    bytes_left_next   = bytes_dec;
                    read_pointer_next = read_pointer_reg + 1'b1;
                    if (bytes_dec == '0)
                    begin
                        if (cfg.loop_enable)
                        begin
                            read_pointer_next = start_pointer;
                            bytes_left_next   = start_length;
                        end
                        else if (cfg.irq_enable)
                        begin
                            irq_pending_next = 1'b1;
                        end
                    end
                end
            end
            OP_ACK:
            begin
                irq_pending_next = 1'b0;
            end
            default:
            begin
                req = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        res.dac_out       = dac_level_reg;
        res.dma_request   = req;
        res.fetch_address = req ? read_pointer_next : '0;
        res.irq_flag      = irq_pending_next;
        res.active        = (bytes_left_next != '0);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bytes_left_reg   <= '0;
            read_pointer_reg <= '0;
            period_count_reg <= PeriodReset;
            bit_index_reg    <= '0;
            shift_byte_reg   <= '0;
            shift_valid_reg  <= 1'b0;
            buffer_byte_reg  <= '0;
            buffer_full_reg  <= 1'b0;
            dac_level_reg    <= '0;
            irq_pending_reg  <= 1'b0;
            fetch_delay_reg  <= '0;
        end
        else if (step_en)
        begin
            bytes_left_reg   <= bytes_left_next;
            read_pointer_reg <= read_pointer_next;
            period_count_reg <= period_count_next;
            bit_index_reg    <= bit_index_next;
            shift_byte_reg   <= shift_byte_next;
            shift_valid_reg  <= shift_valid_next;
            buffer_byte_reg  <= buffer_byte_next;
            buffer_full_reg  <= buffer_full_next;
            dac_level_reg    <= dac_level_next;
            irq_pending_reg  <= irq_pending_next;
            fetch_delay_reg  <= fetch_delay_next;
        end
    end

endmodule

### rtl/delta_modulation_sample_channel.sv
// Delta-modulation sample channel: takes one request per clock (tick, start, stop,
// returned dma byte, irq acknowledge) while in_stall is low and gives one result per
// request, in order. A request is registered on entry; as it leaves the request
// register the channel state and the result are updated, and the result sits in an
// output register until taken. in_stall rises only when both registers are full and
// out_stall holds, so with no stall from downstream the sustained rate is one request
// per cycle. The result's dac_out is the level before the request. Configuration is
// written through the plain write port and is sampled by requests as they are
// processed, so write it only while the channel is idle.
// Depends on dmc_pkg, dmc_cfg and dmc_core.
`timescale 1ns / 1ps

module delta_modulation_sample_channel
    import dmc_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    // configuration write port
    input  logic                    cfg_wr_en,
    input  logic [CfgIdxWidth-1:0]  cfg_index,
    input  logic [CfgDataWidth-1:0] cfg_wdata,
    // request channel
    input  logic                    in_valid,
    output logic                    in_stall,
    input  logic [OpWidth-1:0]      opcode,
    input  logic [ByteWidth-1:0]    dma_byte,
    // result channel
    output logic                    out_valid,
    input  logic                    out_stall,
    output logic [DacWidth-1:0]     dac_out,
    output logic                    dma_request,
    output logic [AddrWidth-1:0]    fetch_address,
    output logic                    irq_flag,
    output logic                    active
);

    cfg_t    cfg;
    result_t res;

    // request register
    logic                 in_valid_reg, in_valid_next;
    logic [OpWidth-1:0]   op_reg;
    logic [ByteWidth-1:0] byte_reg;

    // result register
    logic    out_valid_reg, out_valid_next;
    result_t out_reg;

    logic in_accept;
    logic advance;

    // the held request moves on when the result register is free or being emptied
    assign advance   = in_valid_reg & ~(out_valid_reg & out_stall);
    // only stall upstream when both registers are full and downstream holds
    assign in_stall  = in_valid_reg & out_valid_reg & out_stall;
    assign in_accept = in_valid & ~in_stall;

    assign in_valid_next  = in_accept | (in_valid_reg & ~advance);
    assign out_valid_next = advance | (out_valid_reg & out_stall);

    dmc_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    // state update happens exactly once per request, as it leaves the request register
    dmc_core u_core (
        .clk     (clk),
        .rst_n   (rst_n),
        .step_en (advance),
        .op      (op_reg),
        .data    (byte_reg),
        .cfg     (cfg),
        .res     (res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers, no reset needed
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            op_reg   <= opcode;
            byte_reg <= dma_byte;
        end
        if (advance)
        begin
            out_reg <= res;
        end
    end

    assign out_valid     = out_valid_reg;
    assign dac_out       = out_reg.dac_out;
    assign dma_request   = out_reg.dma_request;
    assign fetch_address = out_reg.fetch_address;
    assign irq_flag      = out_reg.irq_flag;
    assign active        = out_reg.active;

endmodule

### rtl/dmc_checker.sv
// port-level checks of the sample channel, bound to the top level
// depends on dmc_pkg and delta_modulation_sample_channel
`timescale 1ns / 1ps

module dmc_checker
    import dmc_pkg::*;
(
    input logic                 clk,
    input logic                 rst_n,
    input logic                 in_stall,
    input logic                 out_valid,
    input logic                 out_stall,
    input logic [DacWidth-1:0]  dac_out,
    input logic                 dma_request,
    input logic [AddrWidth-1:0] fetch_address
);

    // no address is shown without a bus request
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !dma_request) |-> (fetch_address == '0))
        else $error("fetch_address nonzero without dma_request");

    // a held result keeps its level
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |=> (out_valid && $stable(dac_out)))
        else $error("stalled result changed");

    // consecutive results differ in level by zero or one step of two
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_stall) |=> (!out_valid
            || (dac_out == $past(dac_out))
            || (dac_out == $past(dac_out) + 7'd2)
            || (dac_out == $past(dac_out) - 7'd2)))
        else $error("dac level jumped between results");

    // back-pressure only comes from a stalled full result side
    assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> (out_valid && out_stall))
        else $error("request stalled while result side is free");

endmodule

bind delta_modulation_sample_channel dmc_checker u_dmc_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_stall      (in_stall),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .dac_out       (dac_out),
    .dma_request   (dma_request),
    .fetch_address (fetch_address)
);

### sim/delta_modulation_sample_channel_test.sv
// self-checking testbench of the delta-modulation sample channel: a directed table, then
// random request phases under several register settings, checked against a local predictor
// depends on rtl/dmc_pkg.sv and rtl/delta_modulation_sample_channel.sv
`timescale 1ns / 1ps

module delta_modulation_sample_channel_test;
    import dmc_pkg::*;

    localparam int CycleLimit    = 200000;
    localparam int SettleCycles  = 6;
    localparam int HoldOffCycles = 300;
    localparam int SqueezeAt     = 20;
    localparam int ScriptRows    = 17;

    localparam logic [AddrWidth-1:0] SampleBase   = 15'h4000;
    localparam logic [OpWidth-1:0]   OpUnusedLow  = OP_ACK + 1'b1;
    localparam logic [OpWidth-1:0]   OpUnusedHigh = '1;
    localparam result_t              QuietResult  = '0;

    // one row of the directed table; known_result is used only where known is set
    typedef struct packed {
        logic [OpWidth-1:0]   op;
        logic [ByteWidth-1:0] data;
        logic                 known;
        result_t              known_result;
    } script_row_t;

    logic                    clk;
    logic                    rst_n;
    logic                    cfg_wr_en;
    logic [CfgIdxWidth-1:0]  cfg_index;
    logic [CfgDataWidth-1:0] cfg_wdata;
    logic                    in_valid;
    logic                    in_stall;
    logic [OpWidth-1:0]      opcode;
    logic [ByteWidth-1:0]    dma_byte;
    logic                    out_valid;
    logic                    out_stall;
    logic [DacWidth-1:0]     dac_out;
    logic                    dma_request;
    logic [AddrWidth-1:0]    fetch_address;
    logic                    irq_flag;
    logic                    active;

    delta_modulation_sample_channel i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_index     (cfg_index),
        .cfg_wdata     (cfg_wdata),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .opcode        (opcode),
        .dma_byte      (dma_byte),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .dac_out       (dac_out),
        .dma_request   (dma_request),
        .fetch_address (fetch_address),
        .irq_flag      (irq_flag),
        .active        (active)
    );

    // channel state as the predictor sees it
    cfg_t                   chan_cfg;
    logic [LengthWidth-1:0] remain_cnt;
    logic [AddrWidth-1:0]   rd_addr;
    logic [PeriodWidth-1:0] period_left;
    logic [2:0]             bit_sel;
    logic [ByteWidth-1:0]   shift_reg;
    logic                   shift_full;
    logic [ByteWidth-1:0]   hold_byte;
    logic                   hold_full;
    logic [DacWidth-1:0]    level;
    logic                   irq_latched;
    logic [1:0]             fetch_wait;

    // results still owed by the block, oldest first
    result_t due_results[$];

    int  mismatch_count;
    int  request_count;
    int  setting_count;
    int  fetch_count;
    int  fetches_unanswered;
    int  peak_level;
    int  cycle_count;
    int  gap_pct;
    int  stall_pct;
    bit  hold_off_armed;

    // directed requests: quiet channel after reset, every opcode, both byte extremes,
    // one short sample, start while playing, stop, byte with nothing left to play
    script_row_t request_script [ScriptRows] = '{
        {OP_TICK,      8'h00, 1'b1, QuietResult},
        {OP_ACK,       8'hFF, 1'b1, QuietResult},
        {OP_BYTE,      8'hFF, 1'b1, QuietResult},
        {OP_STOP,      8'h00, 1'b1, QuietResult},
        {OpUnusedLow,  8'h5A, 1'b1, QuietResult},
        {OpUnusedLow + 1'b1, 8'hA5, 1'b1, QuietResult},
        {OpUnusedHigh, 8'hFF, 1'b1, QuietResult},
        {OP_START,     8'h00, 1'b0, QuietResult},
        {OP_TICK,      8'h00, 1'b0, QuietResult},
        {OP_TICK,      8'h00, 1'b0, QuietResult},
        {OP_BYTE,      8'hFF, 1'b0, QuietResult},
        {OP_START,     8'h00, 1'b0, QuietResult},
        {OP_START,     8'hFF, 1'b0, QuietResult},
        {OP_STOP,      8'h00, 1'b0, QuietResult},
        {OP_BYTE,      8'h00, 1'b0, QuietResult},
        {OP_ACK,       8'h00, 1'b0, QuietResult},
        {OP_TICK,      8'hFF, 1'b0, QuietResult}
    };

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // latch the sample start address and length
    function automatic void reload_sample();
        rd_addr    = SampleBase + {chan_cfg.sample_address, 6'b0};
        remain_cnt = {chan_cfg.sample_length, 4'b0} + 1'b1;
    endfunction

    // advance the predicted channel by one request and return the result it owes
    function automatic result_t step_channel(input logic [OpWidth-1:0]   op,
                                             input logic [ByteWidth-1:0] data);
        result_t              res;
        logic                 fetch;
        logic [ByteWidth-1:0] moved;
        res         = '0;
        res.dac_out = level;
        fetch       = 1'b0;
        case (op)
            OP_TICK:
            begin
                period_left = period_left - 1'b1;
                if (period_left == '0)
                begin
                    if (shift_full)
                    begin
                        // a step that leaves 0..127 sets bit 7 and is dropped
                        moved = shift_reg[bit_sel] ? {1'b0, level} + 8'd2
                                                   : {1'b0, level} - 8'd2;
                        if (!moved[7])
                            level = moved[6:0];
                    end
                    bit_sel = bit_sel + 1'b1;
                    if (bit_sel == '0)
                    begin
                        shift_full = hold_full;
                        if (hold_full)
                        begin
                            shift_reg = hold_byte;
                            hold_full = 1'b0;
                            fetch     = (remain_cnt != '0);
                        end
                    end
                    // a reload of zero wraps to 511 on the next tick
                    period_left = chan_cfg.period_reload;
                end
                if (fetch_wait != '0)
                begin
                    fetch_wait = fetch_wait - 1'b1;
                    if (fetch_wait == '0)
                        fetch = 1'b1;
                end
            end
            OP_START:
            begin
                // ignored while a sample is playing
                if (remain_cnt == '0)
                begin
                    reload_sample();
                    if (!hold_full)
                        fetch_wait = period_left[0] ? 2'd2 : 2'd3;
                end
            end
            OP_STOP:
                remain_cnt = '0;
            OP_BYTE:
            begin
                if (remain_cnt != '0)
                begin
                    hold_byte  = data;
                    hold_full  = 1'b1;
                    remain_cnt = remain_cnt - 1'b1;
                    rd_addr    = rd_addr + 1'b1;
                    if (remain_cnt == '0)
                    begin
                        if (chan_cfg.loop_enable)
                            reload_sample();
                        else if (chan_cfg.irq_enable)
                            irq_latched = 1'b1;
                    end
                end
            end
            OP_ACK:
                irq_latched = 1'b0;
            default:
                ;
        endcase
        res.dma_request   = fetch;
        res.fetch_address = fetch ? rd_addr : '0;
        res.irq_flag      = irq_latched;
        res.active        = (remain_cnt != '0);
        return res;
    endfunction

    function automatic void compare_field(input string field, input int unsigned want,
                                          input int unsigned got);
        if (want != got)
        begin
            $display("%0t ns: %s mismatch, expected %0d, got %0d", $time, field, want, got);
            mismatch_count++;
        end
    endfunction

    // queue the owed result, then offer the request until the block takes it
    task automatic offer_request(input logic [OpWidth-1:0]   op,
                                 input logic [ByteWidth-1:0] data,
                                 input result_t              due);
        due_results.push_back(due);
        request_count++;
        if (due.dac_out > peak_level)
            peak_level = due.dac_out;
        // each cycle idles with the sender's idle chance
        while ($urandom_range(99) < gap_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        opcode   <= op;
        dma_byte <= data;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        @(negedge clk);
    endtask

    // stop offering and wait until every owed result is back, then wait SettleCycles more
    task automatic settle_channel();
        in_valid <= 1'b0;
        while (due_results.size() != 0)
            @(negedge clk);
        repeat (SettleCycles) @(negedge clk);
    endtask

    // write all five registers back to back while the channel is idle
    task automatic program_channel(input cfg_t setting);
        cfg_wr_en <= 1'b1;
        cfg_index <= REG_SAMPLE_ADDRESS;
        cfg_wdata <= CfgDataWidth'(setting.sample_address);
        @(negedge clk);
        cfg_index <= REG_SAMPLE_LENGTH;
        cfg_wdata <= CfgDataWidth'(setting.sample_length);
        @(negedge clk);
        cfg_index <= REG_PERIOD_RELOAD;
        cfg_wdata <= setting.period_reload;
        @(negedge clk);
        cfg_index <= REG_LOOP_ENABLE;
        cfg_wdata <= CfgDataWidth'(setting.loop_enable);
        @(negedge clk);
        cfg_index <= REG_IRQ_ENABLE;
        cfg_wdata <= CfgDataWidth'(setting.irq_enable);
        @(negedge clk);
        cfg_wr_en <= 1'b0;
        chan_cfg = setting;
        setting_count++;
    endtask

    // random requests under one setting; the bus side answers predicted fetches with a
    // byte most of the time, the rest is ticks, starts, stray bytes and other noise
    task automatic run_phase(input cfg_t setting, input int gap, input int stall,
                             input int count, input int tick_pct, input int byte_pct,
                             input bit squeeze);
        logic [OpWidth-1:0]   op;
        logic [ByteWidth-1:0] data;
        result_t              due;
        int                   roll;
        settle_channel();
        program_channel(setting);
        gap_pct   = gap;
        stall_pct = stall;
        for (int n = 0; n < count; n++)
        begin
            if (squeeze && n == SqueezeAt)
                hold_off_armed = 1'b1;
            roll = $urandom_range(99);
            if (fetches_unanswered > 0 && $urandom_range(99) < 70)
            begin
                op = OP_BYTE;
                fetches_unanswered--;
            end
            else if (remain_cnt == '0 && roll < 35)
                op = OP_START;
            else if (roll < tick_pct)
                op = OP_TICK;
            else if (roll < tick_pct + byte_pct)
                op = OP_BYTE;
            else
                op = OpWidth'($urandom_range(OpUnusedHigh, OP_STOP));
            // sample bytes lean toward all ones so the level climbs to the top
            roll = $urandom_range(99);
            if (roll < 55)
                data = 8'hFF;
            else if (roll < 70)
                data = 8'h00;
            else
                data = ByteWidth'($urandom);
            due = step_channel(op, data);
            if (due.dma_request)
            begin
                fetches_unanswered++;
                fetch_count++;
            end
            offer_request(op, data, due);
        end
    endtask

    // receiver: random stall, or one long hold-off counted here once armed
    initial
    begin : result_stall
        int hold_left;
        hold_left = 0;
        out_stall = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_off_armed)
            begin
                hold_off_armed = 1'b0;
                hold_left      = HoldOffCycles;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                out_stall <= 1'b1;
            end
            else
                out_stall <= ($urandom_range(99) < stall_pct);
        end
    end

    // each taken result against the oldest owed one
    always @(posedge clk)
    begin : result_check
        result_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (due_results.size() == 0)
            begin
                $display("%0t ns: unexpected result, expected none, got %h", $time,
                         {dac_out, dma_request, fetch_address, irq_flag, active});
                mismatch_count++;
            end
            else
            begin
                want = due_results.pop_front();
                compare_field("dac_out", want.dac_out, dac_out);
                compare_field("dma_request", want.dma_request, dma_request);
                compare_field("fetch_address", want.fetch_address, fetch_address);
                compare_field("irq_flag", want.irq_flag, irq_flag);
                compare_field("active", want.active, active);
            end
        end
    end

    always @(posedge clk)
    begin : watchdog
        cycle_count++;
        if (cycle_count >= CycleLimit)
        begin
            $display("%0t ns: timeout with %0d results owed", $time, due_results.size());
            $display("delta_modulation_sample_channel test failed");
            $finish;
        end
    end

    initial
    begin : stimulus
        script_row_t row;
        result_t     due;

        rst_n     = 1'b0;
        cfg_wr_en = 1'b0;
        cfg_index = REG_SAMPLE_ADDRESS;
        cfg_wdata = '0;
        in_valid  = 1'b0;
        opcode    = OP_TICK;
        dma_byte  = '0;

        // predictor in its reset state
        chan_cfg    = {8'd0, 8'd0, PeriodReset, 1'b0, 1'b0};
        remain_cnt  = '0;
        rd_addr     = '0;
        period_left = PeriodReset;
        bit_sel     = '0;
        shift_reg   = '0;
        shift_full  = 1'b0;
        hold_byte   = '0;
        hold_full   = 1'b0;
        level       = '0;
        irq_latched = 1'b0;
        fetch_wait  = '0;

        mismatch_count     = 0;
        request_count      = 0;
        setting_count      = 0;
        fetch_count        = 0;
        fetches_unanswered = 0;
        peak_level         = 0;
        cycle_count        = 0;
        hold_off_armed     = 1'b0;
        gap_pct            = 36;
        stall_pct          = 61;

        repeat (8) @(negedge clk);
        rst_n <= 1'b1;

        // directed table under the reset register values
        for (int k = 0; k < ScriptRows; k++)
        begin
            row = request_script[k];
            due = step_channel(row.op, row.data);
            if (row.known)
                due = row.known_result;
            offer_request(row.op, row.data, due);
        end

        // mostly ticks: runs the reset period count of 428 down, then one-byte samples
        // from the top start address play out and end in an interrupt
        run_phase({8'hFF, 8'h00, 9'd1, 1'b0, 1'b1}, 36, 61, 460, 99, 1, 1'b0);
        // one-byte looping sample, idle rates swapped
        run_phase({8'h00, 8'h00, 9'd2, 1'b1, 1'b1}, 61, 36, 45, 55, 10, 1'b0);
        // no idling, with the long receiver hold-off so the input backs up
        run_phase({8'h80, 8'h01, 9'd3, 1'b0, 1'b1}, 0, 0, 40, 60, 10, 1'b1);
        // longest looping sample from the top start address, byte heavy
        run_phase({8'hFF, 8'hFF, 9'd1, 1'b1, 1'b0}, 0, 0, 35, 35, 45, 1'b0);
        // reload of zero: the counter wraps to 511 after it next runs out
        run_phase({8'h01, 8'h01, 9'd0, 1'b0, 1'b1}, 0, 0, 12, 92, 3, 1'b0);
        // largest reload
        run_phase({8'h55, 8'h10, 9'd511, 1'b0, 1'b0}, 0, 0, 8, 70, 10, 1'b0);

        settle_channel();
        $display("ran %0d requests under %0d register settings, %0d predicted dma fetches",
                 request_count, setting_count, fetch_count);
        $display("dac level reached %0d, receiver held off once for %0d cycles",
                 peak_level, HoldOffCycles);
        if (mismatch_count == 0 && due_results.size() == 0)
            $display("delta_modulation_sample_channel test passed");
        else
            $display("delta_modulation_sample_channel test failed");
        $finish;
    end

endmodule
